// ----- hw/rtl/srw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srw_pkg
// shared constants, codes and types of the selective-repeat sender window
// ---------------------------------------------------------------------------
package srw_pkg;

	localparam int SEQ_SPACE   = 8;
	localparam int SEQ_W       = $clog2(SEQ_SPACE);
	localparam int WIN         = SEQ_SPACE / 2;
	localparam int WIN_W       = $clog2(WIN);
	localparam int CNT_W       = $clog2(WIN + 1);
	localparam int PAY_W       = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command field of an input word
	typedef enum logic [1:0] {
		CMD_SEND    = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2
	} cmd_t;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_ACK_BAD = 2'd2,
		OP_TIMEOUT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_TRANSMIT    = 3'd0,
		ACT_REFUSED     = 3'd1,
		ACT_RETRANSMIT  = 3'd2,
		ACT_ACK_TAKEN   = 3'd3,
		ACT_ACK_OUTSIDE = 3'd4,
		ACT_ACK_CORRUPT = 3'd5,
		ACT_UNKNOWN_TMO = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		TMR_NONE    = 2'd0,
		TMR_START   = 2'd1,
		TMR_STOP    = 2'd2,
		TMR_RESTART = 2'd3
	} timer_op_t;

	typedef struct packed {
		op_t              op;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] payload;
	} op_entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/srw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srw_front
// accepts input words and classifies them into queue entries
// ---------------------------------------------------------------------------
module srw_front (
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 cmd,
	input  wire logic [srw_pkg::PAY_W-1:0]  payload_word,
	input  wire logic [srw_pkg::SEQ_W-1:0]  seq_number,
	input  wire logic                       checksum_ok,
	input  wire logic                       q_full,
	output logic                            q_push,
	output srw_pkg::op_entry_t              q_entry
);

	logic keep;

	always_comb begin
		keep          = 1'b1;
		q_entry.op    = srw_pkg::OP_SEND;
		q_entry.seq   = seq_number;
		q_entry.payload = payload_word;
		unique case (cmd)
			srw_pkg::CMD_SEND:    q_entry.op = srw_pkg::OP_SEND;
			srw_pkg::CMD_ACK: begin
				q_entry.op = checksum_ok ? srw_pkg::OP_ACK : srw_pkg::OP_ACK_BAD;
			end
			srw_pkg::CMD_TIMEOUT: q_entry.op = srw_pkg::OP_TIMEOUT;
			// undefined command is taken and dropped
			default:              keep = 1'b0;
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

endmodule
`default_nettype wire

// ----- hw/rtl/srw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srw_queue
// short fifo of classified operations between front and back
// ---------------------------------------------------------------------------
module srw_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire srw_pkg::op_entry_t push_entry,
	output logic                    full,
	output logic                    head_valid,
	output srw_pkg::op_entry_t      head_entry,
	input  wire logic               pop
);

	srw_pkg::op_entry_t                ent_q [srw_pkg::QUEUE_DEPTH];
	logic [srw_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [srw_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [srw_pkg::QCNT_W-1:0]        cnt_q;

	assign full       = (cnt_q == srw_pkg::QCNT_W'(srw_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_entry;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/srw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srw_back
// window state, lookup and update, result register
// ---------------------------------------------------------------------------
module srw_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire srw_pkg::op_entry_t         q_entry,
	output logic                            q_pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [2:0]                      action,
	output logic [srw_pkg::SEQ_W-1:0]       pkt_seq,
	output logic [srw_pkg::PAY_W-1:0]       pkt_payload,
	output logic [1:0]                      timer_op,
	output logic                            window_full,
	output logic [srw_pkg::CNT_W-1:0]       in_flight,
	output logic [srw_pkg::SEQ_W-1:0]       window_base
);

	localparam logic [srw_pkg::CNT_W-1:0] WIN_CNT = srw_pkg::CNT_W'(srw_pkg::WIN);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t                         state_q;

	// window state; entry of sequence s lives in slot s mod WIN
	logic [srw_pkg::CNT_W-1:0]      cnt_q;
	logic [srw_pkg::SEQ_W-1:0]      next_q;
	logic [srw_pkg::SEQ_W-1:0]      base_q;
	logic [srw_pkg::WIN-1:0]        marks_q;
	logic [srw_pkg::PAY_W-1:0]      pay_mem [srw_pkg::WIN];

	srw_pkg::op_t                   op_s1;
	logic [srw_pkg::SEQ_W-1:0]      seq_s1;
	logic [srw_pkg::PAY_W-1:0]      pay_s1;
	logic                           hit_s2;
	logic [srw_pkg::PAY_W-1:0]      rdpay_s2;

	srw_pkg::action_t               action_q;
	srw_pkg::timer_op_t             timer_op_q;
	logic                           out_valid_q;
	logic [srw_pkg::SEQ_W-1:0]      pkt_seq_q;
	logic [srw_pkg::PAY_W-1:0]      pkt_payload_q;
	logic                           window_full_q;
	logic [srw_pkg::CNT_W-1:0]      in_flight_q;
	logic [srw_pkg::SEQ_W-1:0]      window_base_q;

	logic                           out_free;
	logic                           commit;
	logic [srw_pkg::SEQ_W-1:0]      seq_off;

	srw_pkg::action_t               act_d;
	srw_pkg::timer_op_t             top_d;
	logic [srw_pkg::SEQ_W-1:0]      pseq_d;
	logic [srw_pkg::PAY_W-1:0]      ppay_d;
	logic [srw_pkg::CNT_W-1:0]      cnt_d;
	logic [srw_pkg::SEQ_W-1:0]      next_d;
	logic [srw_pkg::SEQ_W-1:0]      base_d;
	logic [srw_pkg::WIN-1:0]        marks_d;
	logic                           wr_en;

	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == ST_EXEC) && out_free;
	assign q_pop    = q_valid && ((state_q == ST_IDLE) || commit);
	assign seq_off  = seq_s1 - base_q;

	// execute step: outcome and next window state
	always_comb begin
		logic [srw_pkg::WIN-1:0]    marks_set;
		logic [srw_pkg::WIN-1:0]    clr;
		logic [srw_pkg::CNT_W-1:0]  run;
		logic [srw_pkg::WIN_W-1:0]  idx;
		logic                       alive;

		act_d     = srw_pkg::ACT_UNKNOWN_TMO;
		top_d     = srw_pkg::TMR_NONE;
		pseq_d    = seq_s1;
		ppay_d    = '0;
		cnt_d     = cnt_q;
		next_d    = next_q;
		base_d    = base_q;
		marks_d   = marks_q;
		wr_en     = 1'b0;
		marks_set = marks_q;
		clr       = '0;
		run       = '0;
		idx       = '0;
		alive     = 1'b1;

		unique case (op_s1)
			srw_pkg::OP_SEND: begin
				pseq_d = next_q;
				if (cnt_q < WIN_CNT) begin
					act_d   = srw_pkg::ACT_TRANSMIT;
					top_d   = srw_pkg::TMR_START;
					ppay_d  = pay_s1;
					wr_en   = 1'b1;
					marks_d[next_q[srw_pkg::WIN_W-1:0]] = 1'b0;
					cnt_d   = cnt_q + 1'b1;
					next_d  = next_q + 1'b1;
				end else begin
					act_d = srw_pkg::ACT_REFUSED;
				end
			end
			srw_pkg::OP_ACK_BAD: act_d = srw_pkg::ACT_ACK_CORRUPT;
			srw_pkg::OP_ACK: begin
				top_d = srw_pkg::TMR_STOP;
				if (hit_s2) begin
					act_d = srw_pkg::ACT_ACK_TAKEN;
					marks_set[seq_s1[srw_pkg::WIN_W-1:0]] = 1'b1;
					// drop the leading run of acked entries from the base
					for (int k = 0; k < srw_pkg::WIN; k++) begin
						idx = base_q[srw_pkg::WIN_W-1:0] + srw_pkg::WIN_W'(k);
						if (alive && (srw_pkg::CNT_W'(k) < cnt_q) && marks_set[idx]) begin
							run      = run + 1'b1;
							clr[idx] = 1'b1;
						end else begin
							alive = 1'b0;
						end
					end
					marks_d = marks_set & ~clr;
					cnt_d   = cnt_q - run;
					base_d  = base_q + srw_pkg::SEQ_W'(run);
				end else begin
					act_d = srw_pkg::ACT_ACK_OUTSIDE;
				end
			end
			srw_pkg::OP_TIMEOUT: begin
				if (hit_s2) begin
					act_d  = srw_pkg::ACT_RETRANSMIT;
					top_d  = srw_pkg::TMR_RESTART;
					ppay_d = rdpay_s2;
				end
			end
			default: act_d = srw_pkg::ACT_UNKNOWN_TMO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			next_q      <= '0;
			base_q      <= '0;
			marks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= ST_LOOK;
				end
				ST_LOOK: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (commit) begin
						cnt_q       <= cnt_d;
						next_q      <= next_d;
						base_q      <= base_d;
						marks_q     <= marks_d;
						state_q     <= q_valid ? ST_LOOK : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload store, registered read at lookup
	always_ff @(posedge clk) begin
		if (commit && wr_en)
			pay_mem[next_q[srw_pkg::WIN_W-1:0]] <= pay_s1;
		if (state_q == ST_LOOK)
			rdpay_s2 <= pay_mem[seq_s1[srw_pkg::WIN_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1  <= q_entry.op;
			seq_s1 <= q_entry.seq;
			pay_s1 <= q_entry.payload;
		end
		if (state_q == ST_LOOK)
			hit_s2 <= (srw_pkg::CNT_W'(seq_off) < cnt_q) && (seq_off < srw_pkg::SEQ_W'(srw_pkg::WIN));
		if (commit) begin
			action_q      <= act_d;
			timer_op_q    <= top_d;
			pkt_seq_q     <= pseq_d;
			pkt_payload_q <= ppay_d;
			window_full_q <= (cnt_d == WIN_CNT);
			in_flight_q   <= cnt_d;
			window_base_q <= base_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign timer_op    = timer_op_q;
	assign pkt_seq     = pkt_seq_q;
	assign pkt_payload = pkt_payload_q;
	assign window_full = window_full_q;
	assign in_flight   = in_flight_q;
	assign window_base = window_base_q;

endmodule
`default_nettype wire

// ----- hw/rtl/selective_repeat_sender_window_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// selective_repeat_sender_window_top
// selective-repeat arq sender: window of four outstanding packets over an
// eight-number sequence space
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one command word: send,
//   acknowledgement or timer expiry. command code 3 is taken and dropped.
//   output channel (out_valid / out_stall) carries one result word per
//   command: action, sequence, payload, timer operation and window status.
// processing
//   a taken word passes the queue, then the back end's lookup and update
//   steps, and the update writes the output register. the back end works
//   on one word at a time: it pops the next word only as it commits the
//   last. a two-word queue sits between front and back.
// reset
//   arst_n clears the window: no packets in flight, next and base at 0,
//   all ack marks clear. the payload store is not cleared.
// receiver stall
//   a finished result holds in the output register while out_stall is high;
//   the back end waits in its update step and the queue keeps filling until
//   full, at which point in_stall rises.
// ---------------------------------------------------------------------------
module selective_repeat_sender_window_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command words
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 cmd,
	input  wire logic [srw_pkg::PAY_W-1:0]  payload_word,
	input  wire logic [srw_pkg::SEQ_W-1:0]  seq_number,
	input  wire logic                       checksum_ok,
	// result words
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [2:0]                      action,
	output logic [srw_pkg::SEQ_W-1:0]       pkt_seq,
	output logic [srw_pkg::PAY_W-1:0]       pkt_payload,
	output logic [1:0]                      timer_op,
	output logic                            window_full,
	output logic [srw_pkg::CNT_W-1:0]       in_flight,
	output logic [srw_pkg::SEQ_W-1:0]       window_base
);

	// front to queue
	logic                  q_full;
	logic                  q_push;
	srw_pkg::op_entry_t    q_push_entry;

	// queue to back
	logic                  q_head_valid;
	srw_pkg::op_entry_t    q_head_entry;
	logic                  q_pop;

	// decode of command words, dropping undefined codes
	srw_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.payload_word (payload_word),
		.seq_number   (seq_number),
		.checksum_ok  (checksum_ok),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_push_entry)
	);

	// decouples input acceptance from window processing
	srw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry),
		.pop        (q_pop)
	);

	// window state machine and result register
	srw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_head_valid),
		.q_entry     (q_head_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.action      (action),
		.pkt_seq     (pkt_seq),
		.pkt_payload (pkt_payload),
		.timer_op    (timer_op),
		.window_full (window_full),
		.in_flight   (in_flight),
		.window_base (window_base)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/srw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srw_checker
// port-level checks of the sender window results
// ---------------------------------------------------------------------------
module srw_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic [2:0]                 action,
	input  wire logic [srw_pkg::PAY_W-1:0]  pkt_payload,
	input  wire logic [1:0]                 timer_op,
	input  wire logic                       window_full,
	input  wire logic [srw_pkg::CNT_W-1:0]  in_flight
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action) && $stable(pkt_payload))
		else $error("result changed while stalled");

	// full flag agrees with the count
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_full == (in_flight == srw_pkg::CNT_W'(srw_pkg::WIN))))
		else $error("window_full disagrees with in_flight");

	// count never beyond the window
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (in_flight <= srw_pkg::CNT_W'(srw_pkg::WIN)))
		else $error("in_flight beyond window");

	// a refusal only when the window is full
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == srw_pkg::ACT_REFUSED) |-> window_full)
		else $error("refused with room in window");

	// no payload and no timer for refusals, corrupt acks, unknown timeouts
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((action == srw_pkg::ACT_REFUSED) ||
			(action == srw_pkg::ACT_ACK_CORRUPT) ||
			(action == srw_pkg::ACT_UNKNOWN_TMO))
		|-> (timer_op == srw_pkg::TMR_NONE) && (pkt_payload == '0))
		else $error("payload or timer on a no-op result");

endmodule

bind selective_repeat_sender_window_top srw_checker u_srw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.action      (action),
	.pkt_payload (pkt_payload),
	.timer_op    (timer_op),
	.window_full (window_full),
	.in_flight   (in_flight)
);
`default_nettype wire

// ----- tb/tb_selective_repeat_sender_window_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_selective_repeat_sender_window_top
// self-checking bench for the selective-repeat sender window: directed window
// scenarios, then random send/ack/timeout traffic under four idling phases,
// each result word checked against an in-bench window predictor
// ---------------------------------------------------------------------------
module tb_selective_repeat_sender_window_top;

	// command code 3 is taken by the block and dropped without a result
	localparam logic [1:0] CMD_UNDEF = 2'd3;
	localparam int         WORDS_PER_PHASE = 285;

	// one expected result word
	typedef struct {
		srw_pkg::action_t                 act;
		logic [srw_pkg::SEQ_W-1:0]        seq;
		logic [srw_pkg::PAY_W-1:0]        payload;
		srw_pkg::timer_op_t               tmr;
		logic                             full;
		logic [srw_pkg::CNT_W-1:0]        count;
		logic [srw_pkg::SEQ_W-1:0]        base;
	} window_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                cmd = srw_pkg::CMD_SEND;
	logic [srw_pkg::PAY_W-1:0] payload_word = '0;
	logic [srw_pkg::SEQ_W-1:0] seq_number = '0;
	logic                      checksum_ok = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [2:0]                action;
	logic [srw_pkg::SEQ_W-1:0] pkt_seq;
	logic [srw_pkg::PAY_W-1:0] pkt_payload;
	logic [1:0]                timer_op;
	logic                      window_full;
	logic [srw_pkg::CNT_W-1:0] in_flight;
	logic [srw_pkg::SEQ_W-1:0] window_base;

	// idling percentages of the current phase
	int idle_pct  = 0;
	int stall_pct = 0;
	int mismatches = 0;

	// predicted sender window, oldest entry first
	logic [srw_pkg::PAY_W-1:0] win_payload [srw_pkg::WIN];
	logic [srw_pkg::SEQ_W-1:0] win_seq [srw_pkg::WIN];
	bit                        win_acked [srw_pkg::WIN];
	int                        win_count = 0;
	logic [srw_pkg::SEQ_W-1:0] win_next = '0;
	logic [srw_pkg::SEQ_W-1:0] win_base = '0;

	window_result_t expected_results [$];

	selective_repeat_sender_window_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.payload_word (payload_word),
		.seq_number   (seq_number),
		.checksum_ok  (checksum_ok),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.pkt_seq      (pkt_seq),
		.pkt_payload  (pkt_payload),
		.timer_op     (timer_op),
		.window_full  (window_full),
		.in_flight    (in_flight),
		.window_base  (window_base)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// index of an outstanding sequence number, -1 when not in the window
	function automatic int locate_seq(input logic [srw_pkg::SEQ_W-1:0] s);
		for (int i = 0; i < win_count; i++)
			if (win_seq[i] == s)
				return i;
		return -1;
	endfunction

	// advance the predicted window by one accepted command word and queue
	// the result word it should produce
	task automatic window_step(input logic [1:0] c, input logic [srw_pkg::PAY_W-1:0] pay,
			input logic [srw_pkg::SEQ_W-1:0] sq, input logic ck);
		window_result_t r;
		int idx;
		int run;
		r.act = srw_pkg::ACT_TRANSMIT;
		r.seq = sq;
		r.payload = '0;
		r.tmr = srw_pkg::TMR_NONE;
		if (c == CMD_UNDEF)
			return;
		if (c == srw_pkg::CMD_SEND) begin
			if (win_count < srw_pkg::WIN) begin
				win_payload[win_count] = pay;
				win_seq[win_count] = win_next;
				win_acked[win_count] = 1'b0;
				win_count++;
				r.seq = win_next;
				r.payload = pay;
				r.tmr = srw_pkg::TMR_START;
				// sequence space is a power of two, so the add wraps by itself
				win_next = win_next + 1'b1;
			end else begin
				r.act = srw_pkg::ACT_REFUSED;
				r.seq = win_next;
			end
		end else if (c == srw_pkg::CMD_ACK) begin
			if (!ck) begin
				r.act = srw_pkg::ACT_ACK_CORRUPT;
			end else begin
				idx = locate_seq(sq);
				r.tmr = srw_pkg::TMR_STOP;
				if (idx < 0) begin
					r.act = srw_pkg::ACT_ACK_OUTSIDE;
				end else begin
					r.act = srw_pkg::ACT_ACK_TAKEN;
					win_acked[idx] = 1'b1;
					// drop the leading acked run, the rest move down with marks
					run = 0;
					while (run < win_count && win_acked[run])
						run++;
					for (int i = 0; i + run < win_count; i++) begin
						win_payload[i] = win_payload[i + run];
						win_seq[i] = win_seq[i + run];
						win_acked[i] = win_acked[i + run];
					end
					win_count -= run;
					for (int i = win_count; i < srw_pkg::WIN; i++)
						win_acked[i] = 1'b0;
					win_base = win_base + srw_pkg::SEQ_W'(run);
				end
			end
		end else begin
			idx = locate_seq(sq);
			if (idx < 0) begin
				r.act = srw_pkg::ACT_UNKNOWN_TMO;
			end else begin
				r.act = srw_pkg::ACT_RETRANSMIT;
				r.payload = win_payload[idx];
				r.tmr = srw_pkg::TMR_RESTART;
			end
		end
		r.full = (win_count == srw_pkg::WIN);
		r.count = srw_pkg::CNT_W'(win_count);
		r.base = win_base;
		expected_results.push_back(r);
	endtask

	// offer one command word, with random idle cycles ahead of it, and
	// predict its result once the block takes it
	task automatic send_word(input logic [1:0] c, input logic [srw_pkg::PAY_W-1:0] pay,
			input logic [srw_pkg::SEQ_W-1:0] sq, input logic ck);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		payload_word <= pay;
		seq_number   <= sq;
		checksum_ok  <= ck;
		do
			@(posedge clk);
		while (in_stall);
		window_step(c, pay, sq, ck);
	endtask

	// stop offering words and wait for every predicted result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// pick an outstanding sequence number, or any when the window is empty
	function automatic logic [srw_pkg::SEQ_W-1:0] pick_seq();
		if (win_count == 0)
			return srw_pkg::SEQ_W'($urandom_range(0, srw_pkg::SEQ_SPACE - 1));
		return win_seq[$urandom_range(0, win_count - 1)];
	endfunction

	// mostly well-formed traffic: sends, good acks and timeouts of packets in
	// flight; the rest is corrupt acks, stray sequences and undefined words
	task automatic run_random_words(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_word(srw_pkg::CMD_SEND, $urandom, srw_pkg::SEQ_W'($urandom),
					1'($urandom_range(0, 1)));
			else if (pick < 70)
				send_word(srw_pkg::CMD_ACK, $urandom, pick_seq(), 1'b1);
			else if (pick < 82)
				send_word(srw_pkg::CMD_TIMEOUT, $urandom, pick_seq(),
					1'($urandom_range(0, 1)));
			else if (pick < 88)
				send_word(srw_pkg::CMD_ACK, $urandom, srw_pkg::SEQ_W'($urandom),
					1'($urandom_range(0, 1)));
			else if (pick < 94)
				send_word(srw_pkg::CMD_TIMEOUT, $urandom, srw_pkg::SEQ_W'($urandom),
					1'($urandom_range(0, 1)));
			else
				send_word(CMD_UNDEF, $urandom, srw_pkg::SEQ_W'($urandom),
					1'($urandom_range(0, 1)));
		end
	endtask

	// directed walk through the window: empty-window corner cases, fill and
	// refuse, out-of-order and repeated acks, multi-entry slide, sequence wrap
	task automatic test_window_scenarios();
		idle_pct = 0;
		stall_pct = 0;
		send_word(srw_pkg::CMD_TIMEOUT, '0, 3'd0, 1'b0);         // unknown timeout, empty
		send_word(srw_pkg::CMD_ACK, '0, 3'd0, 1'b1);             // ack outside window
		send_word(srw_pkg::CMD_ACK, '0, 3'd7, 1'b0);             // corrupt ack
		send_word(srw_pkg::CMD_SEND, 32'h0000_0000, 3'd0, 1'b0);
		send_word(srw_pkg::CMD_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1);
		send_word(srw_pkg::CMD_SEND, 32'hA5A5_A5A5, 3'd0, 1'b0);
		send_word(srw_pkg::CMD_SEND, 32'h5A5A_5A5A, 3'd0, 1'b0); // window now full
		send_word(srw_pkg::CMD_SEND, 32'h1234_5678, 3'd0, 1'b0); // refused
		send_word(CMD_UNDEF, 32'hDEAD_BEEF, 3'd5, 1'b1);         // dropped, no result
		send_word(srw_pkg::CMD_TIMEOUT, '0, 3'd2, 1'b0);         // retransmit
		send_word(srw_pkg::CMD_TIMEOUT, '0, 3'd5, 1'b1);         // unknown timeout
		send_word(srw_pkg::CMD_ACK, '0, 3'd2, 1'b1);             // ack of a younger entry
		send_word(srw_pkg::CMD_ACK, '0, 3'd2, 1'b1);             // repeated ack
		send_word(srw_pkg::CMD_ACK, '0, 3'd1, 1'b1);
		send_word(srw_pkg::CMD_ACK, '0, 3'd0, 1'b1);             // slide by three
		send_word(srw_pkg::CMD_TIMEOUT, '0, 3'd3, 1'b0);
		send_word(srw_pkg::CMD_SEND, 32'h0000_0001, 3'd0, 1'b0);
		send_word(srw_pkg::CMD_SEND, 32'h8000_0000, 3'd0, 1'b0);
		send_word(srw_pkg::CMD_SEND, 32'h7FFF_FFFF, 3'd0, 1'b0);
		send_word(srw_pkg::CMD_ACK, '0, 3'd6, 1'b1);             // ack of the newest entry
		send_word(srw_pkg::CMD_ACK, '0, 3'd3, 1'b1);             // slide by one
		send_word(srw_pkg::CMD_SEND, 32'hCAFE_F00D, 3'd0, 1'b0); // takes sequence 7
		send_word(srw_pkg::CMD_ACK, '0, 3'd4, 1'b1);
		send_word(srw_pkg::CMD_ACK, '0, 3'd5, 1'b1);             // slide across marked 6
		send_word(srw_pkg::CMD_SEND, 32'h0BAD_F00D, 3'd0, 1'b0); // sequence wraps to 0
		wait_drained();
	endtask

	task automatic test_no_idling();
		idle_pct = 0;
		stall_pct = 0;
		run_random_words(WORDS_PER_PHASE);
		wait_drained();
	endtask

	task automatic test_sender_gaps();
		idle_pct = 55;
		stall_pct = 0;
		run_random_words(WORDS_PER_PHASE);
		wait_drained();
	endtask

	task automatic test_receiver_stalls();
		idle_pct = 0;
		stall_pct = 55;
		run_random_words(WORDS_PER_PHASE);
		wait_drained();
	endtask

	task automatic test_both_idle();
		idle_pct = 35;
		stall_pct = 35;
		run_random_words(WORDS_PER_PHASE);
		wait_drained();
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// compare every taken result word with the oldest prediction
	always @(posedge clk) begin
		window_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word: action %0d pkt_seq %0d", action, pkt_seq);
				mismatches++;
			end else begin
				e = expected_results.pop_front();
				if (action !== e.act) begin
					$error("action: expected %0d actual %0d", e.act, action);
					mismatches++;
				end
				if (pkt_seq !== e.seq) begin
					$error("pkt_seq: expected %0d actual %0d", e.seq, pkt_seq);
					mismatches++;
				end
				if (pkt_payload !== e.payload) begin
					$error("pkt_payload: expected %h actual %h", e.payload, pkt_payload);
					mismatches++;
				end
				if (timer_op !== e.tmr) begin
					$error("timer_op: expected %0d actual %0d", e.tmr, timer_op);
					mismatches++;
				end
				if (window_full !== e.full) begin
					$error("window_full: expected %0d actual %0d", e.full, window_full);
					mismatches++;
				end
				if (in_flight !== e.count) begin
					$error("in_flight: expected %0d actual %0d", e.count, in_flight);
					mismatches++;
				end
				if (window_base !== e.base) begin
					$error("window_base: expected %0d actual %0d", e.base, window_base);
					mismatches++;
				end
			end
		end
	end

	initial begin
		// hold reset, then release on an edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_window_scenarios();
		test_no_idling();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();

		in_valid <= 1'b0;
		wait_drained();
		// let any stray word behind the last one show up
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
